// ===== src/qslerp_pkg.sv =====
// Shared constants and arctangent table for the quaternion slerp pipeline.
package qslerp_pkg;

    localparam int QS_FRAC_BITS    = 14;
    localparam int QS_CORDIC_STEPS = 16;
    localparam int QS_CW           = 34;

    // 1/K with 30 fraction bits; angles are 2^32 per turn
    localparam logic signed [QS_CW-1:0] QS_INV_GAIN = 34'sd652032874;
    localparam logic signed [QS_CW-1:0] QS_QUARTER  = 34'sd1073741824;

    function automatic logic [QS_CW-1:0] qs_atan(input int idx);
        logic [QS_CW-1:0] val;
        case (idx)
            0:       val = 34'd536870912;
            1:       val = 34'd316933406;
            2:       val = 34'd167458907;
            3:       val = 34'd85004756;
            4:       val = 34'd42667331;
            5:       val = 34'd21354465;
            6:       val = 34'd10679838;
            7:       val = 34'd5340245;
            8:       val = 34'd2670163;
            9:       val = 34'd1335087;
            10:      val = 34'd667544;
            11:      val = 34'd333772;
            12:      val = 34'd166886;
            13:      val = 34'd83443;
            14:      val = 34'd41722;
            15:      val = 34'd20861;
            16:      val = 34'd10430;
            17:      val = 34'd5215;
            18:      val = 34'd2608;
            19:      val = 34'd1304;
            20:      val = 34'd652;
            21:      val = 34'd326;
            22:      val = 34'd163;
            23:      val = 34'd81;
            24:      val = 34'd41;
            25:      val = 34'd20;
            26:      val = 34'd10;
            27:      val = 34'd5;
            28:      val = 34'd3;
            29:      val = 34'd1;
            30:      val = 34'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/qslerp_sqrt_cell.sv =====
// One restoring square-root step; the chain of these yields floor(sqrt(v)).
module qslerp_sqrt_cell #(
    parameter int W      = 61,
    parameter int BITPOS = 60
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] v_in,
    input  logic [W-1:0] r_in,
    output logic [W-1:0] v_out,
    output logic [W-1:0] r_out
);

    localparam logic [W:0] BIT = {{W{1'b0}}, 1'b1} << BITPOS;

    logic [W:0]   trial;
    logic         fit;
    logic [W-1:0] v_reg;
    logic [W-1:0] r_reg;

    always_comb
    begin
        trial = {1'b0, r_in} + BIT;
        fit   = {1'b0, v_in} >= trial;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fit)
            begin
                v_reg <= v_in - trial[W-1:0];
                r_reg <= (r_in >> 1) + BIT[W-1:0];
            end
            else
            begin
                v_reg <= v_in;
                r_reg <= r_in >> 1;
            end
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

// ===== src/qslerp_cordic_cell.sv =====
// One CORDIC micro-rotation, vectoring (drive y to 0) or rotation (drive z to 0).
module qslerp_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [qslerp_pkg::QS_CW-1:0]   x_in,
    input  logic signed [qslerp_pkg::QS_CW-1:0]   y_in,
    input  logic signed [qslerp_pkg::QS_CW-1:0]   z_in,
    output logic signed [qslerp_pkg::QS_CW-1:0]   x_out,
    output logic signed [qslerp_pkg::QS_CW-1:0]   y_out,
    output logic signed [qslerp_pkg::QS_CW-1:0]   z_out
);
    import qslerp_pkg::*;

    localparam logic signed [QS_CW-1:0] ANGLE = $signed(qs_atan(STEP));

    logic signed [QS_CW-1:0] dx;
    logic signed [QS_CW-1:0] dy;
    logic                    cw;
    logic signed [QS_CW-1:0] x_reg;
    logic signed [QS_CW-1:0] y_reg;
    logic signed [QS_CW-1:0] z_reg;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        cw = VECTOR ? (y_in > 0) : (z_in < 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cw)
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + ANGLE;
            end
            else
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - ANGLE;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== src/qslerp_div_cell.sv =====
// One restoring division step for all four lanes sharing a divisor.
module qslerp_div_cell #(
    parameter int NW    = 48,
    parameter int QW    = 16,
    parameter int SHIFT = 0
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [3:0][NW-1:0]    rem_in,
    input  logic [NW-1:0]         den_in,
    input  logic [3:0][QW-1:0]    q_in,
    output logic [3:0][NW-1:0]    rem_out,
    output logic [NW-1:0]         den_out,
    output logic [3:0][QW-1:0]    q_out
);

    localparam logic [QW-1:0] QBIT = {{(QW-1){1'b0}}, 1'b1} << SHIFT;

    logic [NW-1:0]         dsh;
    logic [3:0]            fit;
    logic [3:0][NW-1:0]    rem_reg;
    logic [NW-1:0]         den_reg;
    logic [3:0][QW-1:0]    q_reg;

    always_comb
    begin
        dsh = den_in << SHIFT;
        for (int i = 0; i < 4; i++)
        begin
            fit[i] = rem_in[i] >= dsh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[i] <= fit[i] ? rem_in[i] - dsh : rem_in[i];
                q_reg[i]   <= fit[i] ? (q_in[i] | QBIT) : q_in[i];
            end
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

// ===== src/quaternion_slerp_unit.sv =====
// Throughput: one word per cycle; every stage is a register cell, the whole row stalls
// together only while a result waits at the output.
// Sqrt chains (31 and 32 cells), two CORDIC rows and a 16-cell divider set the depth.
// Reset: near_threshold returns to 16383 and the pipeline empties; no clearing pass.
module quaternion_slerp_unit #(
    parameter int CORDIC_STEPS = qslerp_pkg::QS_CORDIC_STEPS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] a_w,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] b_w,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic [14:0]        fraction,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] r_w,
    output logic signed [15:0] r_x,
    output logic signed [15:0] r_y,
    output logic signed [15:0] r_z,
    output logic               used_linear
);
    import qslerp_pkg::*;

    localparam int   NSQ1    = 31;
    localparam int   NSQ2    = 32;
    localparam int   NDIV    = 16;
    localparam int   NA      = NSQ1 + CORDIC_STEPS;
    localparam logic REG_THR = 1'b0;
    localparam logic [14:0] T_ONE = 15'd1 << QS_FRAC_BITS;
    localparam logic [33:0] D_ONE = 34'd1 << (2 * QS_FRAC_BITS);
    localparam logic [60:0] R_ONE = 61'd1 << 60;

    typedef struct packed {
        logic             vld;
        logic             lin;
        logic [14:0]      t;
        logic [30:0]      d30;
        logic [3:0][15:0] a;
        logic [3:0][16:0] b;
    } actx_t;

    typedef struct packed {
        logic vld;
        logic lin;
        logic zero;
    } bctx_t;

    // |u| can reach 2^30 after a floor shift of a negative value
    typedef struct packed {
        logic             vld;
        logic             lin;
        logic             zero;
        logic [3:0]       neg;
        logic [3:0][30:0] au;
    } cctx_t;

    logic        en;
    logic [14:0] thr_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 15'd16383;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_THR)
        begin
            thr_reg <= pwdata[14:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THR) ? {17'b0, thr_reg} : 32'b0;

    logic             out_valid_reg;
    logic [3:0][15:0] res_reg;
    logic             lin_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- front end: capture, products, dot ----------------
    actx_t s0_reg, s1_reg, s2_reg, s3_reg, s4_reg;
    actx_t s2_next;
    logic signed [31:0] p_reg [4];
    logic signed [33:0] dot;
    logic [33:0]        dabs;
    logic [33:0]        dclip;
    logic [61:0]        sq_reg;
    logic [60:0]        rad_reg;

    always_comb
    begin
        dot  = 34'(p_reg[0]) + 34'(p_reg[1]) + 34'(p_reg[2]) + 34'(p_reg[3]);
        dabs = dot[33] ? 34'(-dot) : 34'(dot);
        dclip = (dabs > D_ONE) ? D_ONE : dabs;
        s2_next     = s1_reg;
        s2_next.lin = dabs > {5'b0, thr_reg, 14'b0};
        s2_next.d30 = {dclip[28:0], 2'b0};
        for (int i = 0; i < 4; i++)
        begin
            s2_next.b[i] = dot[33] ? 17'(-$signed(s1_reg.b[i])) : s1_reg.b[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else if (en)
        begin
            s0_reg.vld <= in_valid;
            s0_reg.lin <= 1'b0;
            s0_reg.t   <= (fraction > T_ONE) ? T_ONE : fraction;
            s0_reg.d30 <= '0;
            s0_reg.a   <= {a_z, a_y, a_x, a_w};
            s0_reg.b   <= {{b_z[15], b_z}, {b_y[15], b_y}, {b_x[15], b_x}, {b_w[15], b_w}};
            s1_reg     <= s0_reg;
            s2_reg     <= s2_next;
            s3_reg     <= s2_reg;
            s4_reg     <= s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                p_reg[i] <= $signed(s0_reg.a[i]) * $signed(s0_reg.b[i][15:0]);
            end
            sq_reg  <= s2_reg.d30 * s2_reg.d30;
            rad_reg <= R_ONE - sq_reg[60:0];
        end
    end

    // ---------------- acos: sqrt row then vectoring row ----------------
    actx_t ca_reg  [NA];
    actx_t ca_prev [NA];
    logic [60:0] q1v [NSQ1+1];
    logic [60:0] q1r [NSQ1+1];
    logic signed [QS_CW-1:0] vx [CORDIC_STEPS+1];
    logic signed [QS_CW-1:0] vy [CORDIC_STEPS+1];
    logic signed [QS_CW-1:0] vz [CORDIC_STEPS+1];

    assign q1v[0] = rad_reg;
    assign q1r[0] = '0;
    assign vx[0]  = {3'b0, ca_reg[NSQ1-1].d30};
    assign vy[0]  = {3'b0, q1r[NSQ1][30:0]};
    assign vz[0]  = '0;

    for (genvar k = 0; k < NSQ1; k++)
    begin : g_sq1
        qslerp_sqrt_cell #(.W(61), .BITPOS(60 - 2 * k)) u_cell (
            .clk   (clk),
            .en    (en),
            .v_in  (q1v[k]),
            .r_in  (q1r[k]),
            .v_out (q1v[k+1]),
            .r_out (q1r[k+1])
        );
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_vec
        qslerp_cordic_cell #(.STEP(j), .VECTOR(1'b1)) u_cell (
            .clk   (clk),
            .en    (en),
            .x_in  (vx[j]),
            .y_in  (vy[j]),
            .z_in  (vz[j]),
            .x_out (vx[j+1]),
            .y_out (vy[j+1]),
            .z_out (vz[j+1])
        );
    end

    for (genvar k = 0; k < NA; k++)
    begin : g_ca
        if (k == 0)
        begin : g_head
            assign ca_prev[k] = s4_reg;
        end
        else
        begin : g_tail
            assign ca_prev[k] = ca_reg[k-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ca_reg[k] <= '0;
            end
            else if (en)
            begin
                ca_reg[k] <= ca_prev[k];
            end
        end
    end

    // ---------------- angle split ----------------
    actx_t c1_reg, c2_reg, c3_reg;
    actx_t c1_next;
    logic signed [QS_CW-1:0] zf;
    logic [30:0] theta;
    logic [30:0] theta_reg, theta2_reg;
    logic [45:0] prod_reg;
    logic [30:0] phi1_reg, phi2_reg;

    always_comb
    begin
        zf = vz[CORDIC_STEPS];
        if (zf < 0)
        begin
            theta = '0;
        end
        else if (zf > QS_QUARTER)
        begin
            theta = QS_QUARTER[30:0];
        end
        else
        begin
            theta = zf[30:0];
        end
        // zero angle falls back to the linear blend
        c1_next     = ca_reg[NA-1];
        c1_next.lin = ca_reg[NA-1].lin || (theta == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg  <= theta;
            prod_reg   <= c1_reg.t * theta_reg;
            theta2_reg <= theta_reg;
            phi2_reg   <= prod_reg[44:14];
            phi1_reg   <= theta2_reg - prod_reg[44:14];
        end
    end

    // ---------------- sines: two rotation rows ----------------
    actx_t cr_reg  [CORDIC_STEPS];
    actx_t cr_prev [CORDIC_STEPS];
    logic signed [QS_CW-1:0] rx1 [CORDIC_STEPS+1];
    logic signed [QS_CW-1:0] ry1 [CORDIC_STEPS+1];
    logic signed [QS_CW-1:0] rz1 [CORDIC_STEPS+1];
    logic signed [QS_CW-1:0] rx2 [CORDIC_STEPS+1];
    logic signed [QS_CW-1:0] ry2 [CORDIC_STEPS+1];
    logic signed [QS_CW-1:0] rz2 [CORDIC_STEPS+1];

    assign rx1[0] = QS_INV_GAIN;
    assign ry1[0] = '0;
    assign rz1[0] = {3'b0, phi1_reg};
    assign rx2[0] = QS_INV_GAIN;
    assign ry2[0] = '0;
    assign rz2[0] = {3'b0, phi2_reg};

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_rot
        qslerp_cordic_cell #(.STEP(j), .VECTOR(1'b0)) u_sin1 (
            .clk   (clk),
            .en    (en),
            .x_in  (rx1[j]),
            .y_in  (ry1[j]),
            .z_in  (rz1[j]),
            .x_out (rx1[j+1]),
            .y_out (ry1[j+1]),
            .z_out (rz1[j+1])
        );
        qslerp_cordic_cell #(.STEP(j), .VECTOR(1'b0)) u_sin2 (
            .clk   (clk),
            .en    (en),
            .x_in  (rx2[j]),
            .y_in  (ry2[j]),
            .z_in  (rz2[j]),
            .x_out (rx2[j+1]),
            .y_out (ry2[j+1]),
            .z_out (rz2[j+1])
        );
        if (j == 0)
        begin : g_head
            assign cr_prev[j] = c3_reg;
        end
        else
        begin : g_tail
            assign cr_prev[j] = cr_reg[j-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cr_reg[j] <= '0;
            end
            else if (en)
            begin
                cr_reg[j] <= cr_prev[j];
            end
        end
    end

    // ---------------- blend ----------------
    actx_t b1_reg;
    bctx_t b2_reg;
    logic signed [QS_CW-1:0] s1v, s2v;
    logic signed [17:0] diff [4];
    logic signed [47:0] ps1_reg [4];
    logic signed [48:0] ps2_reg [4];
    logic signed [33:0] lp_reg  [4];
    logic signed [47:0] v2_reg  [4];

    always_comb
    begin
        s1v = ry1[CORDIC_STEPS];
        s2v = ry2[CORDIC_STEPS];
        for (int i = 0; i < 4; i++)
        begin
            diff[i] = 18'($signed(cr_reg[CORDIC_STEPS-1].b[i]))
                    - 18'($signed(cr_reg[CORDIC_STEPS-1].a[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ps1_reg[i] <= $signed(s1v[31:0]) * $signed(cr_reg[CORDIC_STEPS-1].a[i]);
                ps2_reg[i] <= $signed(s2v[31:0]) * $signed(cr_reg[CORDIC_STEPS-1].b[i]);
                lp_reg[i]  <= $signed({1'b0, cr_reg[CORDIC_STEPS-1].t}) * diff[i];
                if (b1_reg.lin)
                begin
                    v2_reg[i] <= (48'($signed(b1_reg.a[i])) <<< QS_FRAC_BITS)
                               + 48'(lp_reg[i]);
                end
                else
                begin
                    v2_reg[i] <= 48'(ps1_reg[i]) + 48'(ps2_reg[i]);
                end
            end
        end
    end

    // ---------------- normalize: scale, sum of squares ----------------
    bctx_t n1_reg, n2_reg, n3_reg;
    cctx_t n4_reg, n5_reg;
    cctx_t n4_next;
    logic [46:0] av [4];
    logic [46:0] mx01, mx23, mx;
    logic [46:0] mx_reg;
    logic signed [47:0] v3_reg [4];
    logic signed [47:0] v4_reg [4];
    logic [5:0]  pos;
    logic [5:0]  sh;
    logic [5:0]  sh_reg;
    logic        dn_reg;
    logic        zero_n2;
    logic signed [47:0] ush [4];
    logic signed [31:0] u_reg [4];
    logic signed [63:0] usq [4];
    logic [61:0] usq_reg [4];
    logic [62:0] ss_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            av[i] = v2_reg[i][47] ? 47'(-v2_reg[i]) : v2_reg[i][46:0];
        end
        mx01 = (av[0] > av[1]) ? av[0] : av[1];
        mx23 = (av[2] > av[3]) ? av[2] : av[3];
        mx   = (mx01 > mx23) ? mx01 : mx23;

        pos = '0;
        for (int i = 0; i < 47; i++)
        begin
            if (mx_reg[i])
            begin
                pos = 6'(i);
            end
        end
        zero_n2 = (mx_reg == '0);
        if (pos >= 6'd30)
        begin
            sh = pos - 6'd29;
        end
        else if (pos < 6'd29)
        begin
            sh = 6'd29 - pos;
        end
        else
        begin
            sh = '0;
        end

        for (int i = 0; i < 4; i++)
        begin
            ush[i] = dn_reg ? (v4_reg[i] >>> sh_reg) : (v4_reg[i] <<< sh_reg);
            usq[i] = u_reg[i] * u_reg[i];
        end

        n4_next.vld  = n3_reg.vld;
        n4_next.lin  = n3_reg.lin;
        n4_next.zero = n3_reg.zero;
        for (int i = 0; i < 4; i++)
        begin
            n4_next.neg[i] = u_reg[i][31];
            n4_next.au[i]  = u_reg[i][31] ? 31'(-u_reg[i]) : u_reg[i][30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg <= '0;
            b2_reg <= '0;
            n1_reg <= '0;
            n2_reg <= '0;
            n3_reg <= '0;
            n4_reg <= '0;
            n5_reg <= '0;
        end
        else if (en)
        begin
            b1_reg      <= cr_reg[CORDIC_STEPS-1];
            b2_reg.vld  <= b1_reg.vld;
            b2_reg.lin  <= b1_reg.lin;
            b2_reg.zero <= 1'b0;
            n1_reg      <= b2_reg;
            n2_reg.vld  <= n1_reg.vld;
            n2_reg.lin  <= n1_reg.lin;
            n2_reg.zero <= zero_n2;
            n3_reg      <= n2_reg;
            n4_reg      <= n4_next;
            n5_reg      <= n4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx;
            sh_reg <= sh;
            dn_reg <= pos >= 6'd30;
            for (int i = 0; i < 4; i++)
            begin
                v3_reg[i]  <= v2_reg[i];
                v4_reg[i]  <= v3_reg[i];
                u_reg[i]   <= ush[i][31:0];
                usq_reg[i] <= usq[i][61:0];
            end
            ss_reg <= 63'(usq_reg[0]) + 63'(usq_reg[1]) + 63'(usq_reg[2]) + 63'(usq_reg[3]);
        end
    end

    // ---------------- magnitude sqrt row ----------------
    cctx_t cs_reg  [NSQ2];
    cctx_t cs_prev [NSQ2];
    logic [62:0] q2v [NSQ2+1];
    logic [62:0] q2r [NSQ2+1];

    assign q2v[0] = ss_reg;
    assign q2r[0] = '0;

    for (genvar k = 0; k < NSQ2; k++)
    begin : g_sq2
        qslerp_sqrt_cell #(.W(63), .BITPOS(62 - 2 * k)) u_cell (
            .clk   (clk),
            .en    (en),
            .v_in  (q2v[k]),
            .r_in  (q2r[k]),
            .v_out (q2v[k+1]),
            .r_out (q2r[k+1])
        );
        if (k == 0)
        begin : g_head
            assign cs_prev[k] = n5_reg;
        end
        else
        begin : g_tail
            assign cs_prev[k] = cs_reg[k-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cs_reg[k] <= '0;
            end
            else if (en)
            begin
                cs_reg[k] <= cs_prev[k];
            end
        end
    end

    // ---------------- division row: |u| * 2^14 / m, rounded ----------------
    cctx_t d0_reg;
    cctx_t cd_reg  [NDIV];
    cctx_t cd_prev [NDIV];
    logic [31:0]         mag;
    logic [3:0][47:0]    num_reg;
    logic [47:0]         den_reg;
    logic [3:0][47:0]    drem [NDIV+1];
    logic [47:0]         dden [NDIV+1];
    logic [3:0][15:0]    dq   [NDIV+1];

    assign mag = q2r[NSQ2][31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= {16'b0, mag};
            for (int i = 0; i < 4; i++)
            begin
                num_reg[i] <= {3'b0, cs_reg[NSQ2-1].au[i], 14'b0} + {17'b0, mag[31:1]};
            end
        end
    end

    assign drem[0] = num_reg;
    assign dden[0] = den_reg;
    assign dq[0]   = '0;

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        qslerp_div_cell #(.NW(48), .QW(16), .SHIFT(NDIV - 1 - k)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (drem[k]),
            .den_in  (dden[k]),
            .q_in    (dq[k]),
            .rem_out (drem[k+1]),
            .den_out (dden[k+1]),
            .q_out   (dq[k+1])
        );
        if (k == 0)
        begin : g_head
            assign cd_prev[k] = d0_reg;
        end
        else
        begin : g_tail
            assign cd_prev[k] = cd_reg[k-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_reg[k] <= '0;
            end
            else if (en)
            begin
                cd_reg[k] <= cd_prev[k];
            end
        end
    end

    // ---------------- sign, saturate, output word ----------------
    cctx_t            cfin;
    logic [3:0][15:0] res;

    always_comb
    begin
        cfin = cd_reg[NDIV-1];
        for (int i = 0; i < 4; i++)
        begin
            if (cfin.zero)
            begin
                res[i] = '0;
            end
            else if (cfin.neg[i])
            begin
                res[i] = (dq[NDIV][i] > 16'd32768) ? 16'h8000 : 16'(-dq[NDIV][i]);
            end
            else
            begin
                res[i] = (dq[NDIV][i] > 16'd32767) ? 16'h7fff : dq[NDIV][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d0_reg        <= cs_reg[NSQ2-1];
            out_valid_reg <= cfin.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res;
            lin_reg <= cfin.lin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign r_w         = res_reg[0];
    assign r_x         = res_reg[1];
    assign r_y         = res_reg[2];
    assign r_z         = res_reg[3];
    assign used_linear = lin_reg;

endmodule

// ===== verif/quaternion_slerp_unit_tb.sv =====
// Self-checking testbench for the quaternion slerp pipeline.
module quaternion_slerp_unit_tb;
    import qslerp_pkg::*;

    localparam int LATENCY     = 96 + 2 * QS_CORDIC_STEPS;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_NEAR_THRESHOLD = 3'd0;

    typedef struct packed {
        logic signed [15:0] w, x, y, z;
        logic               lin;
    } slerp_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic signed [15:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
    logic signed [15:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
    logic [14:0] fraction = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic used_linear;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int errors = 0;
    int cycles = 0;
    logic [14:0] thresh_model = 15'd16383;
    slerp_result_t expected_results[$];

    quaternion_slerp_unit dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** quaternion_slerp_unit: FAILED **");
            $finish;
        end
    end

    // floor shift right for signed values
    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r = 0, bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0)
        begin
            if (v >= r + bt)
            begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end
            else
                r >>= 1;
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint angle_of(longint x, longint y);
        longint z = 0, dx, dy;
        for (int i = 0; i < QS_CORDIC_STEPS; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(qs_atan(i));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(qs_atan(i));
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
        return z;
    endfunction

    function automatic longint sine_of(longint z);
        longint x = 652032874, y = 0, dx, dy;
        for (int i = 0; i < QS_CORDIC_STEPS; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(qs_atan(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(qs_atan(i));
            end
        end
        return y;
    endfunction

    function automatic slerp_result_t blend_quat(logic signed [15:0] qa[4],
                                                 logic signed [15:0] qb[4],
                                                 logic [14:0] frac);
        longint a[4], b[4], v[4], u[4], dot = 0, t, th, p1, p2, s1, s2, q;
        longint unsigned d, mx = 0, ss = 0, m, mag;
        int sh = 0;
        logic lin;
        logic signed [15:0] o[4];
        slerp_result_t r;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = qa[i];
            b[i] = qb[i];
            dot += a[i] * b[i];
        end
        t = frac;
        if (t > 16384) t = 16384;
        if (dot < 0)
        begin
            for (int i = 0; i < 4; i++) b[i] = -b[i];
            dot = -dot;
        end
        lin = longint'(dot) > (longint'(thresh_model) << 14);
        if (!lin)
        begin
            d = dot;
            if (d > (64'd1 << 28)) d = 64'd1 << 28;
            d = d << 2;
            th = angle_of(d, isqrt((64'd1 << 60) - d * d));
            if (th == 0)
                lin = 1'b1;
            else
            begin
                p2 = fshr(t * th, 14);
                p1 = th - p2;
                s1 = sine_of(p1);
                s2 = sine_of(p2);
                for (int i = 0; i < 4; i++) v[i] = s1 * a[i] + s2 * b[i];
            end
        end
        if (lin)
            for (int i = 0; i < 4; i++) v[i] = a[i] * 16384 + t * (b[i] - a[i]);
        for (int i = 0; i < 4; i++)
        begin
            mag = v[i] < 0 ? -v[i] : v[i];
            if (mag > mx) mx = mag;
        end
        if (mx == 0)
            for (int i = 0; i < 4; i++) o[i] = 0;
        else
        begin
            while ((mx >> sh) >= (64'd1 << 30)) sh++;
            for (int i = 0; i < 4; i++) u[i] = fshr(v[i], sh);
            if (sh == 0)
                while (mx < (64'd1 << 29))
                begin
                    mx <<= 1;
                    for (int i = 0; i < 4; i++) u[i] *= 2;
                end
            for (int i = 0; i < 4; i++) ss += longint'(u[i] * u[i]);
            m = isqrt(ss);
            for (int i = 0; i < 4; i++)
            begin
                mag = u[i] < 0 ? -u[i] : u[i];
                q = ((mag << 14) + (m >> 1)) / m;
                if (u[i] < 0) q = -q;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                o[i] = q[15:0];
            end
        end
        r.w = o[0]; r.x = o[1]; r.y = o[2]; r.z = o[3]; r.lin = lin;
        return r;
    endfunction

    task automatic send_pair(logic signed [15:0] qa[4], logic signed [15:0] qb[4],
                             logic [14:0] frac);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {a_w, a_x, a_y, a_z} <= {qa[0], qa[1], qa[2], qa[3]};
        {b_w, b_x, b_y, b_z} <= {qb[0], qb[1], qb[2], qb[3]};
        fraction <= frac;
        expected_results.push_back(blend_quat(qa, qb, frac));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_threshold(logic [14:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_NEAR_THRESHOLD;
        pwdata <= {17'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        thresh_model = val;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp(bit unitish);
        if (unitish) return $signed(16'($urandom_range(32768))) - 16'sd16384;
        return 16'($urandom);
    endfunction

    task automatic random_pair();
        logic signed [15:0] qa[4], qb[4];
        logic [14:0] fr;
        int kind = $urandom_range(9);
        for (int i = 0; i < 4; i++)
        begin
            qa[i] = rand_comp(kind < 7);
            // close pairs exercise the linear path
            qb[i] = (kind < 3) ? qa[i] + 16'($signed($urandom_range(64)) - 32)
                               : rand_comp(kind < 7);
        end
        fr = (kind == 9) ? 15'($urandom) : 15'($urandom_range(16384));
        send_pair(qa, qb, fr);
    endtask

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with none expected");
                errors++;
            end
            else
            begin
                slerp_result_t e;
                e = expected_results.pop_front();
                if (r_w !== e.w) begin $error("r_w exp %0d got %0d", e.w, r_w); errors++; end
                if (r_x !== e.x) begin $error("r_x exp %0d got %0d", e.x, r_x); errors++; end
                if (r_y !== e.y) begin $error("r_y exp %0d got %0d", e.y, r_y); errors++; end
                if (r_z !== e.z) begin $error("r_z exp %0d got %0d", e.z, r_z); errors++; end
                if (used_linear !== e.lin)
                begin
                    $error("used_linear exp %0d got %0d", e.lin, used_linear);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic signed [15:0] qa[4], qb[4];
        qa = '{16384, 0, 0, 0}; qb = '{0, 16384, 0, 0};
        send_pair(qa, qb, 15'd0);
        send_pair(qa, qb, 15'd8192);
        send_pair(qa, qb, 15'd16384);
        send_pair(qa, qb, 15'h7FFF);               // fraction above one
        send_pair(qa, qa, 15'd5000);               // identical: degenerate angle
        qb = '{-16384, 0, 0, 0};
        send_pair(qa, qb, 15'd4000);               // negative dot
        qa = '{0, 0, 0, 0};
        send_pair(qa, qa, 15'd3000);               // zero magnitude
        qa = '{32767, 32767, 32767, 32767}; qb = '{-32768, -32768, -32768, -32768};
        send_pair(qa, qb, 15'd100);                // extremes, dot above one
        send_pair(qa, qa, 15'd16000);
        qb = '{32767, -32768, 32767, -32768};
        send_pair(qa, qb, 15'd9000);
        qa = '{16384, 0, 0, 0}; qb = '{16383, 181, 0, 0};
        send_pair(qa, qb, 15'd8192);               // near pair
        qa = '{1, 0, 0, 0}; qb = '{0, -1, 0, 0};
        send_pair(qa, qb, 15'd12000);              // tiny inputs
        qa = '{11585, 11585, 0, 0}; qb = '{0, 0, 11585, -11585};
        send_pair(qa, qb, 15'd16383);
        drain();
    endtask

    task automatic test_thresholds();
        logic [14:0] settings[4] = '{15'd0, 15'd16384, 15'd12000, 15'd16383};
        foreach (settings[k])
        begin
            write_threshold(settings[k]);
            repeat (20) random_pair();
            drain();
        end
    endtask

    task automatic test_random();
        int pcts[3][2] = '{'{22, 51}, '{51, 22}, '{0, 0}};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = pcts[p][0];
            recv_idle_pct = pcts[p][1];
            repeat (70) random_pair();
            drain();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_off <= 3 * LATENCY;
        // keep offering until the pipe fills and in_ready drops
        repeat (LATENCY + 40) random_pair();
        drain();
        recv_idle_pct = 30;
        repeat (20) random_pair();
        drain();
        repeat (20) random_pair();
        go_idle();
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_thresholds();
        test_random();
        test_backpressure();
        if (errors == 0)
            $display("** quaternion_slerp_unit: PASSED **");
        else
            $display("** quaternion_slerp_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/qslerp_pkg.sv
src/qslerp_sqrt_cell.sv
src/qslerp_cordic_cell.sv
src/qslerp_div_cell.sv
src/quaternion_slerp_unit.sv
verif/quaternion_slerp_unit_tb.sv
